FILE: hw/rtl/at_response_line_framer_assert.svh
// Assertion macros shared by the response line framer RTL.
// Depends on nothing; SYNTH selects the empty forms.
`ifndef AT_RESPONSE_LINE_FRAMER_ASSERT_SVH
`define AT_RESPONSE_LINE_FRAMER_ASSERT_SVH

`ifndef SYNTH
`define AT_RLF_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("at_rlf assertion failed");
`define AT_RLF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("at_rlf implication failed");
`else
`define AT_RLF_ASSERT(lbl, clk, rstn, expr)
`define AT_RLF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/at_rlf_pkg.sv
// Types, codes and constants of the response line framer.
// No dependencies; imported by every framer module.
`timescale 1ns / 1ps
`default_nettype none

package at_rlf_pkg;

    localparam int SLOTS      = 4;
    localparam int LINE_BYTES = 64;
    localparam int SLOT_W     = 2;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = $clog2(LINE_BYTES + 1);
    localparam int ADDR_W     = $clog2(SLOTS * LINE_BYTES);

    localparam logic [1:0] FN_RX      = 2'd0;
    localparam logic [1:0] FN_READ    = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_NO_SLOT = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;
    localparam logic [1:0] STS_IGNORED = 2'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        PH_START,
        PH_FIRST_END,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        SS_FREE,
        SS_FILLING,
        SS_COMPLETE
    } t_slot_state;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        rx_byte;
        logic [SLOT_W-1:0] slot;
        logic [IDX_W-1:0]  index;
    } t_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd;

    typedef struct packed {
        logic [1:0]        status;
        logic              line_done;
        logic [SLOT_W-1:0] done_slot;
        logic [CNT_W-1:0]  done_length;
        logic              rd_use;
        logic [SLOTS-1:0]  ready_mask;
    } t_s1;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0] pos);
        int a;
        a = int'(slot) * LINE_BYTES + int'(pos);
        return a[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/at_rlf_store.sv
// Line byte store: one write port, one registered read port.
// Depends on at_rlf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module at_rlf_store
    import at_rlf_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_wr  i_wr,
    input  wire t_rd  i_rd,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [SLOTS*LINE_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/at_rlf_framer.sv
// Framing state, slot pool bookkeeping and the first result stage.
// Depends on at_rlf_pkg; drives the ports of at_rlf_store.
`timescale 1ns / 1ps
`default_nettype none

module at_rlf_framer
    import at_rlf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire logic i_accept,
    input  wire logic i_advance,
    output t_wr       o_wr,
    output t_rd       o_rd,
    output t_s1       o_s1,
    output logic      o_s1_valid
);

    t_phase      r_phase, n_phase;
    logic [SLOT_W-1:0] r_filling, n_filling;
    logic [CNT_W-1:0]  r_fill, n_fill;
    t_slot_state r_slot_st [SLOTS];
    t_slot_state n_slot_st [SLOTS];
    logic [CNT_W-1:0]  r_len [SLOTS];
    logic [CNT_W-1:0]  n_len [SLOTS];
    logic [7:0]  r_prev1, n_prev1, r_prev2, n_prev2;
    logic        r_s1_valid;
    t_s1         r_s1, n_s1;

    logic              found;
    logic [SLOT_W-1:0] free_idx;
    logic              is_rx, is_cr, is_lf, can_store, ends;

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_slot_st[s] == SS_FREE) begin
                found    = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    assign is_rx     = i_accept && (i_req.func == FN_RX);
    assign is_cr     = (i_req.rx_byte == CH_CR);
    assign is_lf     = (i_req.rx_byte == CH_LF);
    assign can_store = (r_fill < CNT_W'(LINE_BYTES));
    // a CR two stored bytes back turns this LF into content
    assign ends      = (r_phase == PH_END) && is_lf &&
                       !((r_fill >= CNT_W'(2)) && (r_prev2 == CH_CR));

    always_comb begin
        n_phase = r_phase;
        if (is_rx) begin
            unique case (r_phase)
                PH_START:     if (found) n_phase = PH_FIRST_END;
                PH_FIRST_END: if (is_cr) n_phase = PH_END;
                PH_END:       if (ends)  n_phase = PH_START;
                default:      n_phase = PH_START;
            endcase
        end
    end

    always_comb begin
        logic try_store;
        try_store = 1'b0;
        n_filling = r_filling;
        n_fill    = r_fill;
        n_prev1   = r_prev1;
        n_prev2   = r_prev2;
        for (int s = 0; s < SLOTS; s++) begin
            n_slot_st[s] = r_slot_st[s];
            n_len[s]     = r_len[s];
        end
        n_s1       = '0;
        o_wr.en    = 1'b0;
        o_wr.addr  = mem_addr(r_filling, r_fill);
        o_wr.data  = i_req.rx_byte;
        o_rd.en    = i_accept;
        o_rd.addr  = mem_addr(i_req.slot, CNT_W'(i_req.index));

        if (i_accept) begin
            case (i_req.func)
                FN_RX: begin
                    unique case (r_phase)
                        PH_START: begin
                            if (found) begin
                                n_slot_st[free_idx] = SS_FILLING;
                                n_filling = free_idx;
                                o_wr.en   = 1'b1;
                                o_wr.addr = mem_addr(free_idx, '0);
                                n_fill    = CNT_W'(1);
                                n_prev2   = r_prev1;
                                n_prev1   = i_req.rx_byte;
                            end else begin
                                n_s1.status = STS_NO_SLOT;
                            end
                        end
                        PH_FIRST_END: try_store = 1'b1;
                        PH_END: begin
                            if (ends) begin
                                n_slot_st[r_filling] = SS_COMPLETE;
                                n_len[r_filling]     = r_fill;
                                n_s1.line_done   = 1'b1;
                                n_s1.done_slot   = r_filling;
                                n_s1.done_length = r_fill;
                                n_fill = '0;
                            end else begin
                                try_store = 1'b1;
                            end
                        end
                        default: n_s1.status = STS_IGNORED;
                    endcase
                    if (try_store) begin
                        if (can_store) begin
                            o_wr.en = 1'b1;
                            n_fill  = r_fill + CNT_W'(1);
                            n_prev2 = r_prev1;
                            n_prev1 = i_req.rx_byte;
                        end else begin
                            n_s1.status = STS_FULL;
                        end
                    end
                end
                FN_READ: begin
                    if (r_slot_st[i_req.slot] == SS_COMPLETE) begin
                        n_s1.rd_use = (CNT_W'(i_req.index) < r_len[i_req.slot]);
                    end else begin
                        n_s1.status = STS_IGNORED;
                    end
                end
                FN_RELEASE: begin
                    if (r_slot_st[i_req.slot] == SS_COMPLETE) begin
                        n_slot_st[i_req.slot] = SS_FREE;
                        n_len[i_req.slot]     = '0;
                    end else begin
                        n_s1.status = STS_IGNORED;
                    end
                end
                default: n_s1.status = STS_IGNORED;
            endcase
        end

        for (int s = 0; s < SLOTS; s++) begin
            n_s1.ready_mask[s] = (n_slot_st[s] == SS_COMPLETE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_filling  <= '0;
            r_fill     <= '0;
            r_s1_valid <= 1'b0;
            for (int s = 0; s < SLOTS; s++) begin
                r_slot_st[s] <= SS_FREE;
                r_len[s]     <= '0;
            end
        end else begin
            r_phase   <= n_phase;
            r_filling <= n_filling;
            r_fill    <= n_fill;
            for (int s = 0; s < SLOTS; s++) begin
                r_slot_st[s] <= n_slot_st[s];
                r_len[s]     <= n_len[s];
            end
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev1 <= n_prev1;
        r_prev2 <= n_prev2;
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1       = r_s1;
    assign o_s1_valid = r_s1_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/at_response_line_framer.sv
// Response line framer top level: stream ports, output register, assertions.
// Depends on at_rlf_pkg, at_rlf_framer, at_rlf_store, at_response_line_framer_assert.svh.
//
// Usage:
//   Requests enter on the s_axis channel. tuser carries func (0 received byte,
//   1 read stored byte, 2 release complete slot); tdata carries rx_byte, slot
//   and index. Every request yields exactly one result on m_axis: tuser is the
//   status, tlast flags a completed line, tdata carries done_slot, done_length,
//   read_data and ready_mask.
//   Path: a request's result passes the stage register and then the output
//   register; the line store read is registered alongside the stage
//   register.
//   Throughput: one request per cycle unless m_axis_tready stalls the output. Each
//   request's framing and slot update are settled in the cycle it is accepted, and the
//   store has one write and one read port, so no request has to wait on another.
//   Reset: synchronous, active low; all slots free, framer waiting for a
//   line start, both stages empty. The line store is not cleared.
//   Stall: while m_axis_tready is low the result holds; one more request is
//   taken into the stage register if that is empty, then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "at_response_line_framer_assert.svh"

module at_response_line_framer
    import at_rlf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] rx_byte, [9:8] slot, [15:10] index
    input  wire logic [15:0] i_s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [1:0] done_slot, [8:2] done_length, [16:9] read_data, [20:17] ready_mask
    output logic [23:0]      o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]       o_m_axis_tuser,
    // line_done
    output logic             o_m_axis_tlast
);

    t_req       req;
    t_wr        wr;
    t_rd        rd;
    t_s1        s1;
    logic       s1_valid, advance, accept;
    logic [7:0] rdata;

    logic              r_out_valid;
    logic [1:0]        r_status;
    logic              r_done;
    logic [SLOT_W-1:0] r_dslot;
    logic [CNT_W-1:0]  r_dlen;
    logic [7:0]        r_rdata;
    logic [SLOTS-1:0]  r_mask;

    assign req.func    = i_s_axis_tuser;
    assign req.rx_byte = i_s_axis_tdata[7:0];
    assign req.slot    = i_s_axis_tdata[9:8];
    assign req.index   = i_s_axis_tdata[15:10];

    assign advance         = s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !s1_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    at_rlf_framer u_framer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_accept   (accept),
        .i_advance  (advance),
        .o_wr       (wr),
        .o_rd       (rd),
        .o_s1       (s1),
        .o_s1_valid (s1_valid)
    );

    at_rlf_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_rd    (rd),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= s1.status;
            r_done   <= s1.line_done;
            r_dslot  <= s1.done_slot;
            r_dlen   <= s1.done_length;
            r_rdata  <= s1.rd_use ? rdata : 8'h00;
            r_mask   <= s1.ready_mask;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = r_done;
    assign o_m_axis_tdata  = {3'b000, r_mask, r_rdata, r_dlen, r_dslot};

    `AT_RLF_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !s1_valid, o_s_axis_tready)
    `AT_RLF_ASSERT_IMP(a_done_is_ok, i_clk, i_rst_n, r_out_valid && r_done, r_status == STS_OK)
    `AT_RLF_ASSERT_IMP(a_done_marks_ready, i_clk, i_rst_n, r_out_valid && r_done,
                       r_mask[r_dslot])
    `AT_RLF_ASSERT_IMP(a_data_only_on_read, i_clk, i_rst_n, r_out_valid && (r_rdata != 8'h00),
                       (r_status == STS_OK) && !r_done)

endmodule

`default_nettype wire

FILE: tb/sv/line_framer_checker.sv
`timescale 1ns / 1ps
// Response line framer checker: watches both stream channels, predicts each result
// from the accepted requests and compares results in order. Depends on at_rlf_pkg.
module line_framer_checker
    import at_rlf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // [7:0] rx_byte, [9:8] slot, [15:10] index
    input  wire logic [15:0] i_s_tdata,
    // [1:0] func
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // [1:0] done_slot, [8:2] done_length, [16:9] read_data, [20:17] ready_mask
    input  wire logic [23:0] i_m_tdata,
    // [1:0] status
    input  wire logic [1:0]  i_m_tuser,
    // line_done
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output logic [SLOTS-1:0] o_ready_slots,
    output logic             o_line_open
);

    typedef struct packed {
        logic [1:0]        status;
        logic              line_done;
        logic [SLOT_W-1:0] done_slot;
        logic [CNT_W-1:0]  done_length;
        logic [7:0]        read_data;
        logic [3:0]        ready_mask;
    } t_line_result;

    t_phase            phase;
    logic [SLOT_W-1:0] fill_slot;
    logic [CNT_W-1:0]  fill_cnt;
    t_slot_state       slot_state [SLOTS];
    logic [CNT_W-1:0]  slot_len [SLOTS];
    logic [7:0]        line_mem [SLOTS*LINE_BYTES];
    t_line_result      expected_results [$];

    function automatic logic [1:0] keep_byte(input logic [7:0] b);
        if (fill_cnt >= LINE_BYTES) return STS_FULL;
        line_mem[int'(fill_slot) * LINE_BYTES + int'(fill_cnt)] = b;
        fill_cnt = fill_cnt + 1'b1;
        return STS_OK;
    endfunction

    task automatic frame_request(input t_req r, output t_line_result res);
        logic ends;
        logic found;
        int   s;
        res = '0;
        case (r.func)
            FN_RX: begin
                if (phase == PH_FIRST_END) begin
                    res.status = keep_byte(r.rx_byte);
                    if (r.rx_byte == CH_CR) phase = PH_END;
                end else if (phase == PH_END) begin
                    ends = (r.rx_byte == CH_LF);
                    // LF with a CR two stored bytes back is line content
                    if (ends && fill_cnt >= 2) begin
                        if (line_mem[int'(fill_slot) * LINE_BYTES + int'(fill_cnt) - 2] == CH_CR)
                            ends = 1'b0;
                    end
                    if (ends) begin
                        slot_state[fill_slot] = SS_COMPLETE;
                        slot_len[fill_slot]   = fill_cnt;
                        res.line_done   = 1'b1;
                        res.done_slot   = fill_slot;
                        res.done_length = fill_cnt;
                        fill_cnt = '0;
                        phase    = PH_START;
                    end else begin
                        res.status = keep_byte(r.rx_byte);
                    end
                end else begin
                    found = 1'b0;
                    for (s = 0; s < SLOTS && !found; s++) begin
                        if (slot_state[s] == SS_FREE) begin
                            found     = 1'b1;
                            fill_slot = s[SLOT_W-1:0];
                        end
                    end
                    if (found) begin
                        slot_state[fill_slot] = SS_FILLING;
                        fill_cnt   = '0;
                        res.status = keep_byte(r.rx_byte);
                        phase      = PH_FIRST_END;
                    end else begin
                        res.status = STS_NO_SLOT;
                    end
                end
            end
            FN_READ: begin
                if (slot_state[r.slot] == SS_COMPLETE) begin
                    if (r.index < slot_len[r.slot])
                        res.read_data = line_mem[int'(r.slot) * LINE_BYTES + int'(r.index)];
                end else begin
                    res.status = STS_IGNORED;
                end
            end
            FN_RELEASE: begin
                if (slot_state[r.slot] == SS_COMPLETE) begin
                    slot_state[r.slot] = SS_FREE;
                    slot_len[r.slot]   = '0;
                    for (s = 0; s < LINE_BYTES; s++)
                        line_mem[int'(r.slot) * LINE_BYTES + s] = '0;
                end else begin
                    res.status = STS_IGNORED;
                end
            end
            default: res.status = STS_IGNORED;
        endcase
        for (s = 0; s < SLOTS; s++)
            res.ready_mask[s] = (slot_state[s] == SS_COMPLETE);
    endtask

    always @(posedge i_clk) begin : watch
        t_req         req;
        t_line_result want;
        t_line_result seen;
        logic         bad;
        int           i;
        if (!i_rst_n) begin
            phase     = PH_START;
            fill_slot = '0;
            fill_cnt  = '0;
            for (i = 0; i < SLOTS; i++) begin
                slot_state[i] = SS_FREE;
                slot_len[i]   = '0;
            end
            for (i = 0; i < SLOTS * LINE_BYTES; i++)
                line_mem[i] = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                req.func    = i_s_tuser;
                req.rx_byte = i_s_tdata[7:0];
                req.slot    = i_s_tdata[9:8];
                req.index   = i_s_tdata[15:10];
                frame_request(req, want);
                expected_results.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.status      = i_m_tuser;
                seen.line_done   = i_m_tlast;
                seen.done_slot   = i_m_tdata[1:0];
                seen.done_length = i_m_tdata[8:2];
                seen.read_data   = i_m_tdata[16:9];
                seen.ready_mask  = i_m_tdata[20:17];
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: status %0d last %0b data %h",
                                 i_m_tuser, i_m_tlast, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    bad = (seen.status !== want.status) ||
                          (seen.line_done !== want.line_done) ||
                          (seen.done_slot !== want.done_slot) ||
                          (seen.done_length !== want.done_length) ||
                          (seen.read_data !== want.read_data) ||
                          (seen.ready_mask !== want.ready_mask);
                    if (bad) begin
                        if (o_fail_count < 10)
                            $display({"mismatch: status %0d/%0d done %0b/%0b slot %0d/%0d ",
                                      "len %0d/%0d data %h/%h mask %b/%b (expected/actual)"},
                                     want.status, seen.status, want.line_done, seen.line_done,
                                     want.done_slot, seen.done_slot,
                                     want.done_length, seen.done_length,
                                     want.read_data, seen.read_data,
                                     want.ready_mask, seen.ready_mask);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending   = expected_results.size();
        o_line_open = (phase != PH_START);
        for (i = 0; i < SLOTS; i++)
            o_ready_slots[i] = (slot_state[i] == SS_COMPLETE);
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Response line framer testbench top: clock, reset, request stimulus and verdict.
// Depends on at_rlf_pkg, at_response_line_framer and line_framer_checker.
module testbench
    import at_rlf_pkg::*;
();

    localparam logic [1:0] FN_UNUSED    = 2'd3;
    localparam int         DIRECTED     = 25;
    localparam int         RANDOM_ITEMS = 1900;
    localparam int         STALL_LIMIT  = 3000;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [15:0] s_data  = '0;
    logic [1:0]  s_user  = '0;
    logic        m_ready = 1'b0;
    wire logic        s_ready;
    wire logic        m_valid;
    wire logic [23:0] m_data;
    wire logic [1:0]  m_user;
    wire logic        m_last;

    int               fail_count;
    int               pending;
    logic [SLOTS-1:0] ready_slots;
    logic             line_open;

    int tx_idle = 8;
    int rx_idle = 88;
    int sent    = 0;
    int stall_cycles = 0;

    at_response_line_framer u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    line_framer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tuser     (s_user),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .i_m_tuser     (m_user),
        .i_m_tlast     (m_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_ready_slots (ready_slots),
        .o_line_open   (line_open)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        m_ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(input logic [1:0] f, input logic [7:0] b,
                            input logic [1:0] sl, input logic [5:0] ix);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= f;
        s_data  <= {ix, sl, b};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [1:0] pick_slot();
        logic [1:0] s;
        s = 2'($urandom_range(3));
        if (ready_slots != '0 && $urandom_range(9) != 0) begin
            while (!ready_slots[s]) s = 2'($urandom_range(3));
        end
        return s;
    endfunction

    task automatic send_line();
        int         body;
        int         tries;
        logic [7:0] b;
        body = ($urandom_range(9) == 0) ? int'($urandom_range(70, 55))
                                        : int'($urandom_range(10));
        send_req(FN_RX, 8'($urandom_range(255)), 2'($urandom_range(3)),
                 6'($urandom_range(63)));
        repeat (body) begin
            b = 8'($urandom_range(255));
            if (b == CH_CR) b = "Z";
            send_req(FN_RX, b, 2'($urandom_range(3)), 6'($urandom_range(63)));
        end
        send_req(FN_RX, CH_CR, 2'($urandom_range(3)), 6'($urandom_range(63)));
        if (body < 12 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(2))
                    0:       b = CH_CR;
                    1:       b = CH_LF;
                    default: b = 8'($urandom_range(255));
                endcase
                send_req(FN_RX, b, 2'($urandom_range(3)), 6'($urandom_range(63)));
            end
        end
        tries = 0;
        while (line_open && tries < 4) begin
            send_req(FN_RX, CH_LF, 2'($urandom_range(3)), 6'($urandom_range(63)));
            tries++;
        end
    endtask

    initial begin
        int         pick;
        int         len;
        int         k;
        int         stage;
        logic [1:0] sl;
        stage = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_req(FN_READ, 8'h00, 2'd0, 6'd0);
        send_req(FN_RELEASE, 8'hFF, 2'd1, 6'd63);
        send_req(FN_UNUSED, 8'hFF, 2'd3, 6'd63);
        send_req(FN_RX, "A", 2'd0, 6'd0);
        send_req(FN_RX, "T", 2'd0, 6'd0);
        send_req(FN_RX, CH_CR, 2'd0, 6'd0);
        send_req(FN_RX, CH_LF, 2'd0, 6'd0);
        send_req(FN_READ, 8'h00, 2'd0, 6'd0);
        send_req(FN_READ, 8'h00, 2'd0, 6'd63);
        // line starting with CR: LFs after a doubled CR are stored
        send_req(FN_RX, CH_CR, 2'd0, 6'd0);
        send_req(FN_RX, CH_CR, 2'd0, 6'd0);
        send_req(FN_RX, CH_LF, 2'd0, 6'd0);
        send_req(FN_RX, CH_LF, 2'd0, 6'd0);
        send_req(FN_RX, CH_LF, 2'd0, 6'd0);
        send_req(FN_READ, 8'h00, 2'd1, 6'd2);
        send_req(FN_RX, 8'hFF, 2'd0, 6'd0);
        send_req(FN_RX, CH_CR, 2'd0, 6'd0);
        send_req(FN_RX, CH_LF, 2'd0, 6'd0);
        send_req(FN_RX, 8'h00, 2'd0, 6'd0);
        send_req(FN_RX, CH_CR, 2'd0, 6'd0);
        send_req(FN_RX, CH_LF, 2'd0, 6'd0);
        // all slots complete: start byte is dropped
        send_req(FN_RX, "A", 2'd0, 6'd0);
        send_req(FN_RELEASE, 8'h00, 2'd2, 6'd0);
        send_req(FN_RELEASE, 8'h00, 2'd2, 6'd0);
        send_req(FN_READ, 8'h00, 2'd3, 6'd0);

        while (sent < DIRECTED + RANDOM_ITEMS) begin
            if (stage == 0 && sent >= DIRECTED + RANDOM_ITEMS / 3) begin
                wait_drained();
                tx_idle = 88;
                rx_idle = 8;
                stage   = 1;
            end else if (stage == 1 && sent >= DIRECTED + 2 * RANDOM_ITEMS / 3) begin
                wait_drained();
                tx_idle = 0;
                rx_idle = 0;
                stage   = 2;
            end
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_line();
            end else if (pick < 60) begin
                sl  = pick_slot();
                len = ($urandom_range(15) == 0) ? 64 : int'($urandom_range(1, 8));
                k   = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(63));
                repeat (len) begin
                    send_req(FN_READ, 8'($urandom_range(255)), sl, k[5:0]);
                    k++;
                end
            end else if (pick < 85) begin
                send_req(FN_RELEASE, 8'($urandom_range(255)), pick_slot(),
                         6'($urandom_range(63)));
            end else begin
                send_req(2'($urandom_range(3)), 8'($urandom_range(255)),
                         2'($urandom_range(3)), 6'($urandom_range(63)));
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/at_rlf_pkg.sv
hw/rtl/at_rlf_store.sv
hw/rtl/at_rlf_framer.sv
hw/rtl/at_response_line_framer.sv
tb/sv/line_framer_checker.sv
tb/sv/testbench.sv
